// ----- rtl/scfr_pkg.sv -----
// Shared types and constants of the serial command frame receiver.
// Used by every module under rtl/; depends on nothing.
package scfr_pkg;

  // Widest read store is 16 words, 32 bytes: one byte position fits in 5 bits
  localparam int unsigned PosW = 5;
  // Depth of the queue between the front and back parts
  localparam int unsigned OpqDepth = 2;
  // Config port widths
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [1:0] {
    MODE_BYTE = 2'd0,
    MODE_TICK = 2'd1,
    MODE_MEAS = 2'd2,
    MODE_NOP  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_BAD_LEN = 2'd1,
    ERR_TIMEOUT = 2'd2
  } err_e;

  typedef enum logic [2:0] {
    REG_WRITE_START = 3'd0,
    REG_READ_START  = 3'd1,
    REG_CMD_START   = 3'd2,
    REG_TIMEOUT     = 3'd3,
    REG_MOTOR_VALUE = 3'd4,
    REG_MOTOR_ON    = 3'd5,
    REG_VIBRO_ON    = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    OP_STATUS = 2'd0,
    OP_STORE  = 2'd1,
    OP_REPLY  = 2'd2,
    OP_MEAS   = 2'd3
  } op_kind_e;

  typedef enum logic [1:0] {
    B_IDLE  = 2'd0,
    B_APPLY = 2'd1,
    B_REPLY = 2'd2
  } back_state_e;

  typedef struct packed {
    mode_e       mode;
    logic [7:0]  rx_byte;
    logic [1:0]  meas_index;
    logic [15:0] meas_value;
  } in_item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       tx_last;
    logic       motor_on;
    logic [7:0] motor_duty;
    logic       vibro_on;
    logic       frame_applied;
    err_e       frame_error;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  write_start;
    logic [7:0]  read_start;
    logic [7:0]  cmd_start;
    logic [15:0] timeout_ticks;
    logic [2:0]  motor_value_word;
    logic [2:0]  motor_on_word;
    logic [2:0]  vibro_on_word;
  } cfg_t;

  // One classified item, handed from the front part to the back part
  typedef struct packed {
    op_kind_e        kind;
    logic [PosW-1:0] pos;
    logic [7:0]      data;
    logic            last;
    err_e            err;
    logic [1:0]      midx;
    logic [15:0]     mval;
  } op_t;

endpackage

// ----- rtl/scfr_front.sv -----
// Front part: frame parser and inter-byte timer; classifies each item into an op.
// Depends on scfr_pkg.
module scfr_front #(
  parameter int unsigned READ_WORDS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  scfr_pkg::cfg_t    cfg_i,
  input  logic              take_i,
  input  scfr_pkg::in_item_t item_i,
  output scfr_pkg::op_t     op_o
);
  import scfr_pkg::*;

  localparam int unsigned CntW = $clog2(2 * READ_WORDS + 2);

  logic [CntW-1:0] bcnt_q, bcnt_d;
  logic [7:0]      cmd_q, cmd_d;
  logic            tmr_on_q, tmr_on_d;
  logic [15:0]     tmr_cnt_q, tmr_cnt_d;
  logic            arm, clr;
  logic [PosW-1:0] pos;

  assign pos = PosW'(bcnt_q - CntW'(2));

  // Classify the item and advance the parser
  always_comb begin
    bcnt_d    = bcnt_q;
    cmd_d     = cmd_q;
    tmr_on_d  = tmr_on_q;
    tmr_cnt_d = tmr_cnt_q;
    arm       = 1'b0;
    clr       = 1'b0;
    op_o      = '0;
    op_o.kind = OP_STATUS;
    op_o.err  = ERR_NONE;
    op_o.pos  = pos;
    op_o.data = item_i.rx_byte;
    op_o.last = (pos == PosW'(2 * READ_WORDS - 1));
    op_o.midx = item_i.meas_index;
    op_o.mval = item_i.meas_value;
    if (take_i) begin
      unique case (item_i.mode)
        MODE_BYTE: begin
          if (bcnt_q == '0) begin
            cmd_d  = item_i.rx_byte;
            bcnt_d = CntW'(1);
            arm    = 1'b1;
          end else if (cmd_q == cfg_i.write_start) begin
            if (bcnt_q == CntW'(1)) begin
              if (item_i.rx_byte != 8'(2 * READ_WORDS)) begin
                clr      = 1'b1;
                op_o.err = ERR_BAD_LEN;
              end else begin
                bcnt_d = CntW'(2);
                arm    = 1'b1;
              end
            end else begin
              // payload byte; the final one completes the frame
              op_o.kind = OP_STORE;
              if (op_o.last) begin
                clr = 1'b1;
              end else begin
                bcnt_d = bcnt_q + CntW'(1);
                arm    = 1'b1;
              end
            end
          end else if (cmd_q == cfg_i.read_start) begin
            op_o.kind = OP_REPLY;
            clr       = 1'b1;
          end else begin
            clr = 1'b1;
          end
        end
        MODE_TICK: begin
          if (tmr_on_q) begin
            if (tmr_cnt_q <= 16'd1) begin
              clr      = 1'b1;
              op_o.err = ERR_TIMEOUT;
            end else begin
              tmr_cnt_d = tmr_cnt_q - 16'd1;
            end
          end
        end
        MODE_MEAS: op_o.kind = OP_MEAS;
        default:   op_o.kind = OP_STATUS;
      endcase
    end
    if (arm) begin
      tmr_on_d  = 1'b1;
      tmr_cnt_d = cfg_i.timeout_ticks;
    end
    if (clr) begin
      bcnt_d    = '0;
      cmd_d     = '0;
      tmr_on_d  = 1'b0;
      tmr_cnt_d = '0;
    end
  end

  // Hold parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bcnt_q    <= '0;
      cmd_q     <= '0;
      tmr_on_q  <= 1'b0;
      tmr_cnt_q <= '0;
    end else begin
      bcnt_q    <= bcnt_d;
      cmd_q     <= cmd_d;
      tmr_on_q  <= tmr_on_d;
      tmr_cnt_q <= tmr_cnt_d;
    end
  end

endmodule

// ----- rtl/scfr_opq.sv -----
// Short op queue between the front and back parts.
// Depends on scfr_pkg.
module scfr_opq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  scfr_pkg::op_t op_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output scfr_pkg::op_t op_o
);
  import scfr_pkg::*;

  localparam int unsigned PtrW = (OpqDepth > 1) ? $clog2(OpqDepth) : 1;
  localparam int unsigned CntW = $clog2(OpqDepth + 1);

  op_t             mem_q [OpqDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(OpqDepth));
  assign empty_o = (cnt_q == '0);
  assign op_o    = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= PtrW'(wr_ptr_q + 1'b1);
      if (do_pop)  rd_ptr_q <= PtrW'(rd_ptr_q + 1'b1);
      if (do_push && !do_pop) cnt_q <= cnt_q + CntW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CntW'(1);
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= op_i;
  end

endmodule

// ----- rtl/scfr_back.sv -----
// Back part: read store, measurement store, frame apply, reply burst, result register.
// Depends on scfr_pkg.
module scfr_back #(
  parameter int unsigned READ_WORDS  = 8,
  parameter int unsigned WRITE_WORDS = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  scfr_pkg::cfg_t      cfg_i,
  input  logic                op_valid_i,
  input  scfr_pkg::op_t       op_i,
  output logic                op_take_o,
  input  logic                out_pop_i,
  output logic                out_valid_o,
  output scfr_pkg::out_item_t out_item_o
);
  import scfr_pkg::*;

  localparam int unsigned AW  = (READ_WORDS > 1) ? $clog2(READ_WORDS) : 1;
  localparam int unsigned MW  = (WRITE_WORDS > 1) ? $clog2(WRITE_WORDS) : 1;
  localparam int unsigned RcW = $clog2(2 * WRITE_WORDS + 2);
  localparam logic [4:0] RwL = 5'(READ_WORDS);
  localparam logic [4:0] WwL = 5'(WRITE_WORDS);

  // Read store as low and high byte halves
  logic [7:0]  mem_lo [READ_WORDS];
  logic [7:0]  mem_hi [READ_WORDS];
  logic [15:0] meas_q [WRITE_WORDS];

  back_state_e     state_q, state_d;
  logic [1:0]      step_q, step_d;
  logic [RcW-1:0]  rcnt_q, rcnt_d;
  logic            out_valid_q;
  out_item_t       out_q;
  logic            motor_on_q, vibro_q;
  logic [7:0]      duty_q;
  logic [7:0]      duty_tmp_q;
  logic            on_tmp_q;
  logic [7:0]      rd_lo_q, rd_hi_q;
  logic            rd_ok_q;

  logic            can_load, load;
  out_item_t       res;
  logic            rd_en, mem_we, meas_we, apply_done;
  logic [2:0]      rd_idx;
  logic [AW-1:0]   rd_addr, wr_addr;
  logic [15:0]     rd_word;
  logic [RcW-1:0]  mb;
  logic [MW-1:0]   widx;
  logic [15:0]     mword;

  assign can_load    = !out_valid_q || out_pop_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign wr_addr = AW'(op_i.pos[PosW-1:1]);
  assign rd_word = rd_ok_q ? {rd_hi_q, rd_lo_q} : 16'd0;

  // Word index for the apply step
  always_comb begin
    case (step_q)
      2'd0:    rd_idx = cfg_i.motor_value_word;
      2'd1:    rd_idx = cfg_i.motor_on_word;
      default: rd_idx = cfg_i.vibro_on_word;
    endcase
  end
  assign rd_addr = AW'(rd_idx);

  // Reply byte select from the measurement words
  assign mb    = rcnt_q - RcW'(2);
  assign widx  = MW'(mb >> 1);
  assign mword = meas_q[widx];

  // Next state, memory strobes and result assembly
  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    rcnt_d     = rcnt_q;
    op_take_o  = 1'b0;
    load       = 1'b0;
    rd_en      = 1'b0;
    mem_we     = 1'b0;
    meas_we    = 1'b0;
    apply_done = 1'b0;
    res               = '0;
    res.frame_error   = ERR_NONE;
    res.motor_on      = motor_on_q;
    res.motor_duty    = duty_q;
    res.vibro_on      = vibro_q;
    unique case (state_q)
      B_IDLE: begin
        if (op_valid_i && can_load) begin
          op_take_o = 1'b1;
          case (op_i.kind)
            OP_STORE: begin
              mem_we = 1'b1;
              if (op_i.last) begin
                state_d = B_APPLY;
                step_d  = 2'd0;
              end else begin
                load        = 1'b1;
                res.tx_last = 1'b1;
              end
            end
            OP_REPLY: begin
              state_d = B_REPLY;
              rcnt_d  = '0;
            end
            OP_MEAS: begin
              meas_we     = ({3'b000, op_i.midx} < WwL);
              load        = 1'b1;
              res.tx_last = 1'b1;
            end
            default: begin
              load            = 1'b1;
              res.tx_last     = 1'b1;
              res.frame_error = op_i.err;
            end
          endcase
        end
      end
      B_APPLY: begin
        if (step_q != 2'd3) begin
          rd_en  = 1'b1;
          step_d = step_q + 2'd1;
        end else if (can_load) begin
          apply_done        = 1'b1;
          load              = 1'b1;
          res.tx_last       = 1'b1;
          res.frame_applied = 1'b1;
          res.motor_on      = on_tmp_q;
          res.motor_duty    = on_tmp_q ? duty_tmp_q : duty_q;
          res.vibro_on      = (rd_word != 16'd0);
          state_d           = B_IDLE;
        end
      end
      B_REPLY: begin
        if (can_load) begin
          load         = 1'b1;
          res.tx_valid = 1'b1;
          if (rcnt_q == '0)             res.tx_byte = cfg_i.write_start;
          else if (rcnt_q == RcW'(1))   res.tx_byte = 8'(2 * WRITE_WORDS);
          else if (mb[0])               res.tx_byte = mword[15:8];
          else                          res.tx_byte = mword[7:0];
          if (rcnt_q == RcW'(2 * WRITE_WORDS + 1)) begin
            res.tx_last = 1'b1;
            state_d     = B_IDLE;
          end else begin
            rcnt_d = rcnt_q + RcW'(1);
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  // Hold control state, held outputs and measurement words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      step_q      <= '0;
      rcnt_q      <= '0;
      out_valid_q <= 1'b0;
      motor_on_q  <= 1'b0;
      duty_q      <= '0;
      vibro_q     <= 1'b0;
      for (int i = 0; i < WRITE_WORDS; i++) meas_q[i] <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      rcnt_q  <= rcnt_d;
      if (load)           out_valid_q <= 1'b1;
      else if (out_pop_i) out_valid_q <= 1'b0;
      if (apply_done) begin
        motor_on_q <= on_tmp_q;
        if (on_tmp_q) duty_q <= duty_tmp_q;
        vibro_q <= (rd_word != 16'd0);
      end
      if (meas_we) meas_q[MW'(op_i.midx)] <= op_i.mval;
    end
  end

  // Latch the result and the apply intermediates
  always_ff @(posedge clk_i) begin
    if (load) out_q <= res;
    if (rd_en && step_q == 2'd1) duty_tmp_q <= rd_word[7:0];
    if (rd_en && step_q == 2'd2) on_tmp_q <= (rd_word != 16'd0);
  end

  // Read store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      if (op_i.pos[0]) mem_hi[wr_addr] <= op_i.data;
      else             mem_lo[wr_addr] <= op_i.data;
    end
    if (rd_en) begin
      rd_lo_q <= mem_lo[rd_addr];
      rd_hi_q <= mem_hi[rd_addr];
      rd_ok_q <= ({2'b00, rd_idx} < RwL);
    end
  end

endmodule

// ----- rtl/serial_command_frame_receiver.sv -----
// Top level of the serial command frame receiver: config registers, front, queue, back.
// Depends on scfr_pkg, scfr_front, scfr_opq and scfr_back.
//
//   channel   handshake                 payload
//   input     push / full               in_item_i  (mode, rx_byte, meas_index, meas_value)
//   result    empty / pop               out_item_o (tx and status fields)
//   config    cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// In the back part, an item that completes a write frame goes through three registered
// reads of the read store through its single port before its result is loaded. After
// taking the op, a read reply sends 2*WRITE_WORDS+2 bytes out of the result register, one
// byte per cycle while the result register is popped. The front accepts items into a
// two-entry op queue while the back part works or the result waits; reset clears the parser,
// result valid flag, motor, duty and vibrator outputs and measurement words at once.
module serial_command_frame_receiver #(
  parameter int unsigned READ_WORDS  = 8,
  parameter int unsigned WRITE_WORDS = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  scfr_pkg::in_item_t              in_item_i,
  output logic                            empty,
  input  logic                            pop,
  output scfr_pkg::out_item_t             out_item_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [scfr_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [scfr_pkg::CfgDataW-1:0]   cfg_data_i
);
  import scfr_pkg::*;

  cfg_t cfg_q;
  op_t  front_op, queue_op;
  logic take, q_full, q_empty, op_take, out_valid;

  assign cfg_ready_o = 1'b1;
  assign full        = q_full;
  assign take        = push && !q_full;
  assign empty       = !out_valid;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.write_start      <= 8'd1;
      cfg_q.read_start       <= 8'd2;
      cfg_q.cmd_start        <= 8'd3;
      cfg_q.timeout_ticks    <= 16'd200;
      cfg_q.motor_value_word <= 3'd0;
      cfg_q.motor_on_word    <= 3'd1;
      cfg_q.vibro_on_word    <= 3'd2;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_WRITE_START: cfg_q.write_start      <= cfg_data_i[7:0];
        REG_READ_START:  cfg_q.read_start       <= cfg_data_i[7:0];
        REG_CMD_START:   cfg_q.cmd_start        <= cfg_data_i[7:0];
        REG_TIMEOUT:     cfg_q.timeout_ticks    <= cfg_data_i;
        REG_MOTOR_VALUE: cfg_q.motor_value_word <= cfg_data_i[2:0];
        REG_MOTOR_ON:    cfg_q.motor_on_word    <= cfg_data_i[2:0];
        REG_VIBRO_ON:    cfg_q.vibro_on_word    <= cfg_data_i[2:0];
        default:         cfg_q <= cfg_q;
      endcase
    end
  end

  scfr_front #(
    .READ_WORDS (READ_WORDS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .take_i (take),
    .item_i (in_item_i),
    .op_o   (front_op)
  );

  scfr_opq u_opq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (take),
    .op_i    (front_op),
    .full_o  (q_full),
    .pop_i   (op_take),
    .empty_o (q_empty),
    .op_o    (queue_op)
  );

  scfr_back #(
    .READ_WORDS  (READ_WORDS),
    .WRITE_WORDS (WRITE_WORDS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .op_valid_i  (!q_empty),
    .op_i        (queue_op),
    .op_take_o   (op_take),
    .out_pop_i   (pop),
    .out_valid_o (out_valid),
    .out_item_o  (out_item_o)
  );

endmodule

// ----- verif/serial_command_frame_receiver_test.sv -----
// Self-checking testbench for serial_command_frame_receiver: frames, replies, timeouts, config.
// Depends on rtl/scfr_pkg.sv and the receiver RTL; reads nothing at run time.
`timescale 1ns / 100ps

module serial_command_frame_receiver_test;
  import scfr_pkg::*;

  localparam int unsigned READ_WORDS  = 8;
  localparam int unsigned WRITE_WORDS = 4;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic push;
  logic full;
  in_item_t in_item_i;
  logic empty;
  logic pop = 1'b0;
  out_item_t out_item_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  // Shadow of the receiver: parser, stores, outputs and registers
  cfg_t shadow;
  int frame_pos;
  logic [7:0] frame_cmd;
  logic [7:0] frame_len;
  logic [7:0] frame_bytes [2*READ_WORDS];
  logic [15:0] meas_words [WRITE_WORDS];
  logic [15:0] ticks_left;
  bit timer_on;
  bit motor_on_q;
  logic [7:0] duty_q;
  bit vibro_q;

  // Results the receiver still owes, oldest first
  out_item_t owed[$];
  out_item_t want;
  logic [15:0] frame_words [READ_WORDS];
  int fail_count = 0;
  int items_sent;
  int pop_hold = 0;
  int results_seen = 0;
  int results_paced = 0;
  bit steady;

  serial_command_frame_receiver #(
    .READ_WORDS (READ_WORDS),
    .WRITE_WORDS(WRITE_WORDS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic void clear_parser();
    frame_pos = 0;
    frame_cmd = '0;
    frame_len = '0;
    timer_on = 1'b0;
    ticks_left = '0;
  endfunction

  function automatic void arm_timer();
    timer_on = 1'b1;
    ticks_left = shadow.timeout_ticks;
  endfunction

  // Little-endian word of the received write payload; out of range reads zero
  function automatic logic [15:0] stored_word(logic [2:0] idx);
    if (idx >= READ_WORDS) return '0;
    return {frame_bytes[2*idx+1], frame_bytes[2*idx]};
  endfunction

  // Advance the shadow by one item and queue the results it must produce
  function automatic void predict_item(in_item_t it);
    logic [7:0] burst [$];
    int count;
    bit applied;
    err_e err;
    out_item_t r;
    applied = 1'b0;
    err = ERR_NONE;
    case (it.mode)
      MODE_BYTE: begin
        if (frame_pos == 0) begin
          frame_cmd = it.rx_byte;
          frame_pos = 1;
          arm_timer();
        end else if (frame_cmd == shadow.write_start) begin
          if (frame_pos == 1) begin
            frame_len = it.rx_byte;
            frame_pos = 2;
            if (frame_len != 2*READ_WORDS) begin
              clear_parser();
              err = ERR_BAD_LEN;
            end else begin
              arm_timer();
            end
          end else if (frame_pos - 2 < frame_len && frame_pos - 2 < 2*READ_WORDS) begin
            frame_bytes[frame_pos-2] = it.rx_byte;
            frame_pos++;
            if (frame_pos - 2 == frame_len) begin
              clear_parser();
              // Motor off keeps the previous duty
              if (stored_word(shadow.motor_on_word) != 0) begin
                motor_on_q = 1'b1;
                duty_q = 8'(stored_word(shadow.motor_value_word));
              end else begin
                motor_on_q = 1'b0;
              end
              vibro_q = stored_word(shadow.vibro_on_word) != 0;
              applied = 1'b1;
            end else begin
              arm_timer();
            end
          end else begin
            clear_parser();
          end
        end else if (frame_cmd == shadow.read_start) begin
          burst.push_back(shadow.write_start);
          burst.push_back(8'(2*WRITE_WORDS));
          for (int k = 0; k < WRITE_WORDS; k++) begin
            burst.push_back(meas_words[k][7:0]);
            burst.push_back(meas_words[k][15:8]);
          end
          clear_parser();
        end else begin
          clear_parser();
        end
      end
      MODE_TICK: begin
        if (timer_on) begin
          if (ticks_left <= 1) begin
            clear_parser();
            err = ERR_TIMEOUT;
          end else begin
            ticks_left--;
          end
        end
      end
      MODE_MEAS: begin
        if (it.meas_index < WRITE_WORDS) meas_words[it.meas_index] = it.meas_value;
      end
      default: ;
    endcase
    count = (burst.size() > 0) ? burst.size() : 1;
    for (int k = 0; k < count; k++) begin
      r.tx_valid = burst.size() > 0;
      r.tx_byte = (burst.size() > 0) ? burst[k] : 8'h00;
      r.tx_last = (k == count - 1);
      r.motor_on = motor_on_q;
      r.motor_duty = duty_q;
      r.vibro_on = vibro_q;
      r.frame_applied = applied;
      r.frame_error = err;
      owed.push_back(r);
    end
  endfunction

  function automatic void check_field(string name, logic [15:0] wantv, logic [15:0] gotv);
    if (gotv !== wantv) begin
      $error("%s: expected %0h, got %0h", name, wantv, gotv);
      fail_count++;
    end
  endfunction

  // Check each result transaction against the oldest owed result
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (owed.size() == 0) begin
        $error("unexpected result: %p", out_item_o);
        fail_count++;
      end else begin
        want = owed.pop_front();
        check_field("tx_valid", want.tx_valid, out_item_o.tx_valid);
        check_field("tx_byte", want.tx_byte, out_item_o.tx_byte);
        check_field("tx_last", want.tx_last, out_item_o.tx_last);
        check_field("motor_on", want.motor_on, out_item_o.motor_on);
        check_field("motor_duty", want.motor_duty, out_item_o.motor_duty);
        check_field("vibro_on", want.vibro_on, out_item_o.vibro_on);
        check_field("frame_applied", want.frame_applied, out_item_o.frame_applied);
        check_field("frame_error", want.frame_error, out_item_o.frame_error);
      end
      results_seen++;
    end
  end

  // Draw a stall after each result transaction, then hold pop low for it
  always @(negedge clk_i) begin
    if (results_paced != results_seen) begin
      results_paced = results_seen;
      pop_hold = steady ? 0 : $urandom_range(0, 7);
    end
    if (pop_hold > 0) begin
      pop <= 1'b0;
      pop_hold--;
    end else begin
      pop <= 1'b1;
    end
  end

  task automatic send_item(in_item_t it);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 7);
    repeat (gap) begin
      @(negedge clk_i);
      push <= 1'b0;
    end
    @(negedge clk_i);
    push <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (full);
    predict_item(it);
    items_sent++;
  endtask

  // Item of the given mode with every other field random
  function automatic in_item_t noise_item(mode_e m);
    in_item_t it;
    it.mode = m;
    it.rx_byte = 8'($urandom);
    it.meas_index = 2'($urandom);
    it.meas_value = 16'($urandom);
    return it;
  endfunction

  task automatic send_byte(logic [7:0] b);
    in_item_t it;
    it = noise_item(MODE_BYTE);
    it.rx_byte = b;
    send_item(it);
  endtask

  task automatic send_tick();
    send_item(noise_item(MODE_TICK));
  endtask

  task automatic send_meas(logic [1:0] idx, logic [15:0] value);
    in_item_t it;
    it = noise_item(MODE_MEAS);
    it.meas_index = idx;
    it.meas_value = value;
    send_item(it);
  endtask

  // Write frame carrying frame_words, with occasional ticks between payload bytes
  task automatic send_write_frame(logic [7:0] len, int tick_max);
    send_byte(shadow.write_start);
    send_byte(len);
    for (int b = 0; b < 2*READ_WORDS; b++) begin
      if (tick_max > 0 && $urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, tick_max)) send_tick();
      send_byte(b[0] ? frame_words[b/2][15:8] : frame_words[b/2][7:0]);
    end
  endtask

  // Hold the input side until every owed result has come
  task automatic wait_drained();
    @(negedge clk_i);
    push <= 1'b0;
    while (owed.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_register(cfg_reg_e idx, logic [15:0] value);
    logic [15:0] data;
    data = value;
    // Junk above the register width must be dropped
    case (idx)
      REG_TIMEOUT: ;
      REG_MOTOR_VALUE, REG_MOTOR_ON, REG_VIBRO_ON: data[15:3] = 13'($urandom);
      default: data[15:8] = 8'($urandom);
    endcase
    wait_drained();
    repeat (8) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_WRITE_START: shadow.write_start = data[7:0];
      REG_READ_START:  shadow.read_start = data[7:0];
      REG_CMD_START:   shadow.cmd_start = data[7:0];
      REG_TIMEOUT:     shadow.timeout_ticks = data;
      REG_MOTOR_VALUE: shadow.motor_value_word = data[2:0];
      REG_MOTOR_ON:    shadow.motor_on_word = data[2:0];
      REG_VIBRO_ON:    shadow.vibro_on_word = data[2:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic configure(logic [7:0] ws, logic [7:0] rs, logic [7:0] cs, logic [15:0] tmo,
                           logic [2:0] mv, logic [2:0] mo, logic [2:0] vo);
    write_register(REG_WRITE_START, ws);
    write_register(REG_READ_START, rs);
    write_register(REG_CMD_START, cs);
    write_register(REG_TIMEOUT, tmo);
    write_register(REG_MOTOR_VALUE, mv);
    write_register(REG_MOTOR_ON, mo);
    write_register(REG_VIBRO_ON, vo);
  endtask

  // Load all measurement slots, then request the reply burst
  task automatic test_reply_burst();
    send_meas(2'd0, 16'hFFFF);
    send_meas(2'd1, 16'h0000);
    send_meas(2'd2, 16'hA55A);
    send_meas(2'd3, 16'h5AA5);
    send_byte(shadow.read_start);
    send_byte(8'hFF);
  endtask

  // Complete write frame that turns motor and vibrator on
  task automatic test_write_frame();
    foreach (frame_words[i]) frame_words[i] = 16'hFFFF;
    frame_words[0] = 16'h12AB;
    frame_words[1] = 16'h0001;
    frame_words[2] = 16'h8000;
    send_write_frame(8'(2*READ_WORDS), 0);
  endtask

  // Bad length, command frame, unknown command, idle tick, no-op
  task automatic test_dropped_frames();
    send_byte(shadow.write_start);
    send_byte(8'hFF);
    send_byte(shadow.cmd_start);
    send_byte(8'h00);
    send_byte(8'hC4);
    send_byte(shadow.read_start);
    send_tick();
    send_item(noise_item(MODE_NOP));
  endtask

  // Expiry with timeouts of one, zero and two ticks
  task automatic test_timeout();
    write_register(REG_TIMEOUT, 16'd1);
    send_byte(8'h55);
    send_tick();
    write_register(REG_TIMEOUT, 16'd0);
    send_byte(8'h55);
    send_tick();
    write_register(REG_TIMEOUT, 16'd2);
    send_byte(shadow.write_start);
    send_tick();
    send_tick();
  endtask

  // Equal command registers: write wins over read, read over command
  task automatic test_register_overlap();
    configure(8'hFF, 8'hFF, 8'hFF, 16'd200, 3'd0, 3'd1, 3'd2);
    send_byte(8'hFF);
    send_byte(8'h00);
    write_register(REG_WRITE_START, 8'h00);
    send_byte(8'hFF);
    send_byte(8'h33);
  endtask

  // Mostly well-formed frames with random content, plus noise and broken frames
  task automatic random_traffic(int quota, bit pause_midway);
    int stop_at;
    int kind;
    bit paused;
    stop_at = items_sent + quota;
    paused = !pause_midway;
    while (items_sent < stop_at) begin
      if (!paused && items_sent >= stop_at - quota / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        foreach (frame_words[i])
          frame_words[i] = ($urandom_range(0, 9) < 3) ? 16'h0000 : 16'($urandom);
        send_write_frame(($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'(2*READ_WORDS), 2);
      end else if (kind < 55) begin
        send_byte(shadow.read_start);
        if ($urandom_range(0, 3) == 0) send_tick();
        send_byte(8'($urandom));
      end else if (kind < 70) begin
        send_meas(2'($urandom), 16'($urandom));
      end else if (kind < 80) begin
        send_byte(($urandom_range(0, 1) == 0) ? shadow.cmd_start : 8'($urandom));
        send_byte(8'($urandom));
      end else if (kind < 90) begin
        repeat ($urandom_range(1, 4)) send_tick();
      end else begin
        send_item(noise_item(mode_e'($urandom_range(0, 3))));
      end
    end
  endtask

  // Several register settings, extremes included, with idle and busy stretches
  task automatic test_random_phases();
    configure(8'd1, 8'd2, 8'd3, 16'd200, 3'd0, 3'd1, 3'd2);
    random_traffic(30, 1'b0);
    steady = 1'b1;
    configure(8'hFF, 8'h00, 8'h80, 16'hFFFF, 3'd7, 3'd7, 3'd7);
    random_traffic(30, 1'b0);
    steady = 1'b0;
    configure(8'($urandom), 8'($urandom), 8'($urandom), 16'd4,
              3'($urandom), 3'($urandom), 3'($urandom));
    random_traffic(30, 1'b1);
    configure(8'h00, 8'hFF, 8'h7F, 16'd1, 3'd0, 3'd0, 3'd0);
    random_traffic(30, 1'b0);
    repeat (2) begin
      configure(8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom_range(1, 300)),
                3'($urandom), 3'($urandom), 3'($urandom));
      random_traffic(30, 1'b0);
    end
  endtask

  initial begin
    push = 1'b0;
    in_item_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    rst_ni = 1'b0;
    steady = 1'b0;
    items_sent = 0;
    shadow = '{write_start: 8'd1, read_start: 8'd2, cmd_start: 8'd3, timeout_ticks: 16'd200,
               motor_value_word: 3'd0, motor_on_word: 3'd1, vibro_on_word: 3'd2};
    clear_parser();
    foreach (frame_bytes[i]) frame_bytes[i] = '0;
    foreach (meas_words[i]) meas_words[i] = '0;
    motor_on_q = 1'b0;
    duty_q = '0;
    vibro_q = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reply_burst();
    test_write_frame();
    test_dropped_frames();
    test_timeout();
    test_register_overlap();
    test_random_phases();

    wait_drained();
    repeat (30) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("serial_command_frame_receiver_test: done, clean");
    end else begin
      $display("serial_command_frame_receiver_test: done, errors");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #3000000;
    $display("serial_command_frame_receiver_test: done, errors");
    $finish;
  end

endmodule
